// ===== rtl/prs_pkg.sv =====
`timescale 1ns / 1ps

package prs_pkg;

    localparam int COL_W     = 8;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 31;
    localparam int INV_W     = 17;
    localparam int SUM_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 63;
    localparam int COLS      = 256;
    localparam int MUL_A_W   = DATA_W + 1;
    localparam int MUL_B_W   = DATA_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 56;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAST_COL  = 3'd0,
        CFG_LAST_ROW  = 3'd1,
        CFG_COEF_X    = 3'd2,
        CFG_COEF_Y    = 3'd3,
        CFG_INV_DIAG  = 3'd4,
        CFG_MODE      = 3'd5,
        CFG_THRESHOLD = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3,
        S_M1, S_M2, S_M3, S_M4, S_T, S_RES, S_M5, S_M6, S_ACC,
        S_EMIT_I, S_EMIT_B, S_WR
    } state_t;

    typedef enum logic [1:0] {RDS_I, RDS_R, RDS_L} rd_sel_t;
    typedef enum logic [1:0] {CAP_NONE, CAP_I, CAP_R, CAP_L} cap_t;
    typedef enum logic [2:0] {
        MOP_NONE, MOP_LR, MOP_UD, MOP_CX, MOP_CY, MOP_INV, MOP_SQ
    } mul_op_t;
    typedef enum logic [1:0] {TOP_NONE, TOP_INIT, TOP_ADD, TOP_SUB2} t_op_t;

    typedef struct packed {
        logic    accept;
        rd_sel_t rd_sel;
        cap_t    cap;
        mul_op_t mul_op;
        t_op_t   t_op;
        logic    load_res;
        logic    load_nv;
        logic    acc_sq;
        logic    emit_int;
        logic    emit_bnd;
        logic    wr;
    } cmd_t;

    typedef struct packed {
        logic interior;
        logic boundary;
    } status_t;

    // one line buffer entry per column
    typedef struct packed {
        logic signed [DATA_W-1:0] two_above;
        logic signed [DATA_W-1:0] old_above;
        logic signed [DATA_W-1:0] rhs_above;
        logic signed [DATA_W-1:0] new_above;
    } mem_word_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (x > hi) begin
            return hi[DATA_W-1:0];
        end else if (x < lo) begin
            return lo[DATA_W-1:0];
        end else begin
            return x[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/poisson_relaxation_sweep.sv =====
`timescale 1ns / 1ps
// One relaxation sweep of the 5-point Poisson stencil over a raster-ordered grid.
// Input channel (s_*): one word per grid point, old value and right-hand side,
// column fastest. Output channel (m_*): up to two words per input word, the
// interior point of the row above first, then the input's own boundary point.
// The word for the last grid point carries sweep_done, the saturated sum of
// squared residuals and the converged flag; counters and sum then restart.
// Configuration (cfg_*): index and data, always ready; the user must see that
// it is written only while idle, which the block itself does not enforce.
// Each input word runs through the whole sequence before the next is accepted;
// the pace is set by the line buffer, with one read and one write port (three
// reads of column words), and the one shared 33x32 multiplier that computes
// the four stencil products, the correction and the square in turn.
// Output valid rises from an emit step: for a boundary point after the reads,
// for an interior point after the reads, the stencil sum, the residual, the
// correction, the square and the accumulation.
// Reset (aresetn low, synchronous) clears the sequencer, counters, sum and the
// configuration to its defaults; the line buffer is not cleared.
// A stalled receiver holds the output word; the sequencer waits in its emit step
// and takes no new input word until the pending words are loaded.
module poisson_relaxation_sweep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [prs_pkg::DATA_W-1:0] s_old_value,
    input  logic signed [prs_pkg::DATA_W-1:0] s_rhs_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [prs_pkg::COL_W-1:0]         m_col_index,
    output logic [prs_pkg::COL_W-1:0]         m_row_index,
    output logic signed [prs_pkg::DATA_W-1:0] m_new_value,
    output logic signed [prs_pkg::DATA_W-1:0] m_residual,
    output logic                              m_sweep_done,
    output logic [prs_pkg::SUM_W-1:0]         m_sum_squares,
    output logic                              m_converged,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prs_pkg::CFG_DAT_W-1:0]     cfg_data
);

    prs_pkg::cmd_t    cmd;
    prs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    prs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    prs_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_old_value   (s_old_value),
        .s_rhs_value   (s_rhs_value),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_col_index   (m_col_index),
        .m_row_index   (m_row_index),
        .m_new_value   (m_new_value),
        .m_residual    (m_residual),
        .m_sweep_done  (m_sweep_done),
        .m_sum_squares (m_sum_squares),
        .m_converged   (m_converged)
    );

endmodule

// ===== rtl/prs_ctrl.sv =====
`timescale 1ns / 1ps

module prs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  prs_pkg::status_t status,
    output prs_pkg::cmd_t    cmd
);

    prs_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == prs_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;

    // hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= prs_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // sequence one word through reads, multiplies, emits and the line buffer write
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.rd_sel   = prs_pkg::RDS_I;
        cmd.cap      = prs_pkg::CAP_NONE;
        cmd.mul_op   = prs_pkg::MOP_NONE;
        cmd.t_op     = prs_pkg::TOP_NONE;
        unique case (state_reg)
            prs_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = prs_pkg::S_RD0;
                end
            end
            prs_pkg::S_RD0: begin
                cmd.rd_sel = prs_pkg::RDS_I;
                state_next = prs_pkg::S_RD1;
            end
            prs_pkg::S_RD1: begin
                cmd.rd_sel = prs_pkg::RDS_R;
                cmd.cap    = prs_pkg::CAP_I;
                state_next = prs_pkg::S_RD2;
            end
            prs_pkg::S_RD2: begin
                cmd.rd_sel = prs_pkg::RDS_L;
                cmd.cap    = prs_pkg::CAP_R;
                state_next = prs_pkg::S_RD3;
            end
            prs_pkg::S_RD3: begin
                cmd.cap = prs_pkg::CAP_L;
                if (status.interior) begin
                    state_next = prs_pkg::S_M1;
                end else if (status.boundary) begin
                    state_next = prs_pkg::S_EMIT_B;
                end else begin
                    state_next = prs_pkg::S_WR;
                end
            end
            prs_pkg::S_M1: begin
                cmd.mul_op = prs_pkg::MOP_LR;
                cmd.t_op   = prs_pkg::TOP_INIT;
                state_next = prs_pkg::S_M2;
            end
            prs_pkg::S_M2: begin
                cmd.mul_op = prs_pkg::MOP_UD;
                cmd.t_op   = prs_pkg::TOP_ADD;
                state_next = prs_pkg::S_M3;
            end
            prs_pkg::S_M3: begin
                cmd.mul_op = prs_pkg::MOP_CX;
                cmd.t_op   = prs_pkg::TOP_ADD;
                state_next = prs_pkg::S_M4;
            end
            prs_pkg::S_M4: begin
                cmd.mul_op = prs_pkg::MOP_CY;
                cmd.t_op   = prs_pkg::TOP_SUB2;
                state_next = prs_pkg::S_T;
            end
            prs_pkg::S_T: begin
                cmd.t_op   = prs_pkg::TOP_SUB2;
                state_next = prs_pkg::S_RES;
            end
            prs_pkg::S_RES: begin
                cmd.load_res = 1'b1;
                state_next   = prs_pkg::S_M5;
            end
            prs_pkg::S_M5: begin
                cmd.mul_op = prs_pkg::MOP_INV;
                state_next = prs_pkg::S_M6;
            end
            prs_pkg::S_M6: begin
                cmd.mul_op  = prs_pkg::MOP_SQ;
                cmd.load_nv = 1'b1;
                state_next  = prs_pkg::S_ACC;
            end
            prs_pkg::S_ACC: begin
                cmd.acc_sq = 1'b1;
                state_next = prs_pkg::S_EMIT_I;
            end
            prs_pkg::S_EMIT_I: begin
                if (out_free) begin
                    cmd.emit_int = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = status.boundary ? prs_pkg::S_EMIT_B : prs_pkg::S_WR;
                end
            end
            prs_pkg::S_EMIT_B: begin
                if (out_free) begin
                    cmd.emit_bnd = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = prs_pkg::S_WR;
                end
            end
            prs_pkg::S_WR: begin
                cmd.wr     = 1'b1;
                state_next = prs_pkg::S_IDLE;
            end
            default: begin
                state_next = prs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/prs_dp.sv =====
`timescale 1ns / 1ps

module prs_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  prs_pkg::cmd_t                       cmd,
    output prs_pkg::status_t                    status,
    input  logic signed [prs_pkg::DATA_W-1:0]   s_old_value,
    input  logic signed [prs_pkg::DATA_W-1:0]   s_rhs_value,
    input  logic                                cfg_valid,
    input  logic [prs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prs_pkg::CFG_DAT_W-1:0]       cfg_data,
    output logic [prs_pkg::COL_W-1:0]           m_col_index,
    output logic [prs_pkg::COL_W-1:0]           m_row_index,
    output logic signed [prs_pkg::DATA_W-1:0]   m_new_value,
    output logic signed [prs_pkg::DATA_W-1:0]   m_residual,
    output logic                                m_sweep_done,
    output logic [prs_pkg::SUM_W-1:0]           m_sum_squares,
    output logic                                m_converged
);

    // configuration registers
    logic [prs_pkg::COL_W-1:0]     last_col_reg, last_row_reg;
    logic [prs_pkg::COEF_W-1:0]    coef_x_reg, coef_y_reg;
    logic [prs_pkg::INV_W-1:0]     inv_diag_reg;
    logic                          mode_reg;
    logic [prs_pkg::SUM_W-1:0]     thr_reg;

    // sweep state
    logic [prs_pkg::COL_W-1:0]     col_cnt_reg, row_cnt_reg;
    logic [prs_pkg::COL_W-1:0]     i_reg, j_reg;
    logic [prs_pkg::SUM_W-1:0]     acc_reg;
    logic signed [prs_pkg::DATA_W-1:0] new_left_reg;

    // per-word payload
    logic signed [prs_pkg::DATA_W-1:0] old_reg, rhs_reg;
    prs_pkg::mem_word_t            word_i_reg, word_r_reg, word_l_reg, rd_q;
    prs_pkg::mem_word_t            line_mem [prs_pkg::COLS];
    prs_pkg::mem_word_t            wr_word;
    logic [prs_pkg::COL_W-1:0]     rd_addr;

    // arithmetic
    logic signed [prs_pkg::MUL_A_W-1:0] mul_a;
    logic signed [prs_pkg::MUL_B_W-1:0] mul_b;
    logic signed [prs_pkg::PROD_W-1:0]  prod_reg;
    logic signed [prs_pkg::PROD_W-1:0]  prod_shr;
    logic signed [prs_pkg::ACC_W-1:0]   term, t_reg;
    logic signed [prs_pkg::DATA_W-1:0]  res_reg, nv_reg;
    logic signed [prs_pkg::DATA_W-1:0]  l_val, u_val;
    logic [prs_pkg::SUM_W:0]            sq_sum;
    logic                               restart, done, last_in_row;

    assign restart     = (col_cnt_reg > last_col_reg) || (row_cnt_reg > last_row_reg);
    assign done        = (i_reg == last_col_reg) && (j_reg == last_row_reg);
    assign last_in_row = (i_reg == last_col_reg);

    assign status.interior = (j_reg >= prs_pkg::COL_W'(2))
                          && ((j_reg - prs_pkg::COL_W'(1)) < last_row_reg)
                          && (i_reg >= prs_pkg::COL_W'(1)) && (i_reg < last_col_reg);
    assign status.boundary = (j_reg == '0) || (j_reg == last_row_reg)
                          || (i_reg == '0) || (i_reg == last_col_reg);

    // take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= 8'd255;
            last_row_reg <= 8'd255;
            coef_x_reg   <= 31'd65536;
            coef_y_reg   <= 31'd65536;
            inv_diag_reg <= 17'd8192;
            mode_reg     <= 1'b0;
            thr_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (prs_pkg::cfg_idx_t'(cfg_index))
                prs_pkg::CFG_LAST_COL:  last_col_reg <= cfg_data[prs_pkg::COL_W-1:0];
                prs_pkg::CFG_LAST_ROW:  last_row_reg <= cfg_data[prs_pkg::COL_W-1:0];
                prs_pkg::CFG_COEF_X:    coef_x_reg   <= cfg_data[prs_pkg::COEF_W-1:0];
                prs_pkg::CFG_COEF_Y:    coef_y_reg   <= cfg_data[prs_pkg::COEF_W-1:0];
                prs_pkg::CFG_INV_DIAG:  inv_diag_reg <= cfg_data[prs_pkg::INV_W-1:0];
                prs_pkg::CFG_MODE:      mode_reg     <= cfg_data[0];
                prs_pkg::CFG_THRESHOLD: thr_reg      <= cfg_data[prs_pkg::SUM_W-1:0];
                default: ;
            endcase
        end
    end

    // advance counters, sum and left value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            acc_reg      <= '0;
            new_left_reg <= '0;
        end else begin
            if (cmd.accept && restart) begin
                acc_reg <= '0;
            end else if (cmd.acc_sq) begin
                acc_reg <= sq_sum[prs_pkg::SUM_W] ? prs_pkg::SUM_MAX
                                                  : sq_sum[prs_pkg::SUM_W-1:0];
            end else if (cmd.wr && done) begin
                acc_reg <= '0;
            end
            if (cmd.wr) begin
                if (done) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                end else if (last_in_row) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= j_reg + prs_pkg::COL_W'(1);
                end else begin
                    col_cnt_reg <= i_reg + prs_pkg::COL_W'(1);
                    row_cnt_reg <= j_reg;
                end
                if (i_reg == '0) begin
                    new_left_reg <= word_i_reg.rhs_above;
                end else if (status.interior) begin
                    new_left_reg <= nv_reg;
                end
            end
        end
    end

    // latch the word, its grid position and the line buffer reads
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            old_reg <= s_old_value;
            rhs_reg <= s_rhs_value;
            i_reg   <= restart ? '0 : col_cnt_reg;
            j_reg   <= restart ? '0 : row_cnt_reg;
        end
        unique case (cmd.cap)
            prs_pkg::CAP_I:    word_i_reg <= rd_q;
            prs_pkg::CAP_R:    word_r_reg <= rd_q;
            prs_pkg::CAP_L:    word_l_reg <= rd_q;
            prs_pkg::CAP_NONE: ;
            default: ;
        endcase
    end

    // line buffer: one read and one write port
    always_comb begin
        unique case (cmd.rd_sel)
            prs_pkg::RDS_R: rd_addr = i_reg + prs_pkg::COL_W'(1);
            prs_pkg::RDS_L: rd_addr = i_reg - prs_pkg::COL_W'(1);
            default:        rd_addr = i_reg;
        endcase
        wr_word.two_above = word_i_reg.old_above;
        wr_word.old_above = old_reg;
        wr_word.rhs_above = rhs_reg;
        if (status.boundary) begin
            wr_word.new_above = rhs_reg;
        end else if (status.interior) begin
            wr_word.new_above = nv_reg;
        end else begin
            wr_word.new_above = word_i_reg.new_above;
        end
    end

    always_ff @(posedge aclk) begin
        rd_q <= line_mem[rd_addr];
        if (cmd.wr) begin
            line_mem[i_reg] <= wr_word;
        end
    end

    // select multiplier operands
    always_comb begin
        l_val = mode_reg ? new_left_reg : word_l_reg.two_above;
        u_val = mode_reg ? word_i_reg.new_above : word_i_reg.two_above;
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            prs_pkg::MOP_LR: begin
                mul_a = prs_pkg::MUL_A_W'(l_val) + prs_pkg::MUL_A_W'(word_r_reg.old_above);
                mul_b = prs_pkg::MUL_B_W'(coef_x_reg);
            end
            prs_pkg::MOP_UD: begin
                mul_a = prs_pkg::MUL_A_W'(u_val) + prs_pkg::MUL_A_W'(old_reg);
                mul_b = prs_pkg::MUL_B_W'(coef_y_reg);
            end
            prs_pkg::MOP_CX: begin
                mul_a = prs_pkg::MUL_A_W'(word_i_reg.old_above);
                mul_b = prs_pkg::MUL_B_W'(coef_x_reg);
            end
            prs_pkg::MOP_CY: begin
                mul_a = prs_pkg::MUL_A_W'(word_i_reg.old_above);
                mul_b = prs_pkg::MUL_B_W'(coef_y_reg);
            end
            prs_pkg::MOP_INV: begin
                mul_a = prs_pkg::MUL_A_W'(res_reg);
                mul_b = prs_pkg::MUL_B_W'(inv_diag_reg);
            end
            prs_pkg::MOP_SQ: begin
                mul_a = prs_pkg::MUL_A_W'(res_reg);
                mul_b = res_reg;
            end
            default: ;
        endcase
        // floor of the product in Q16.16
        prod_shr = prod_reg >>> prs_pkg::FRAC_BITS;
        term     = prod_shr[prs_pkg::ACC_W-1:0];
        sq_sum   = {1'b0, acc_reg} + {1'b0, prod_reg[prs_pkg::SUM_W-1:0]};
    end

    // shared multiplier, stencil sum, residual and relaxed value
    always_ff @(posedge aclk) begin
        prod_reg <= prs_pkg::PROD_W'(mul_a) * prs_pkg::PROD_W'(mul_b);
        unique case (cmd.t_op)
            prs_pkg::TOP_INIT: t_reg <= prs_pkg::ACC_W'(word_i_reg.rhs_above);
            prs_pkg::TOP_ADD:  t_reg <= t_reg + term;
            prs_pkg::TOP_SUB2: t_reg <= t_reg - (term <<< 1);
            prs_pkg::TOP_NONE: ;
            default: ;
        endcase
        if (cmd.load_res) begin
            res_reg <= prs_pkg::sat32(t_reg);
        end
        if (cmd.load_nv) begin
            nv_reg <= prs_pkg::sat32(prs_pkg::ACC_W'(word_i_reg.old_above) + term);
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.emit_int) begin
            m_col_index   <= i_reg;
            m_row_index   <= j_reg - prs_pkg::COL_W'(1);
            m_new_value   <= nv_reg;
            m_residual    <= res_reg;
            m_sweep_done  <= 1'b0;
            m_sum_squares <= '0;
            m_converged   <= 1'b0;
        end else if (cmd.emit_bnd) begin
            m_col_index   <= i_reg;
            m_row_index   <= j_reg;
            m_new_value   <= rhs_reg;
            m_residual    <= '0;
            m_sweep_done  <= done;
            m_sum_squares <= done ? acc_reg : '0;
            m_converged   <= done && (acc_reg < thr_reg);
        end
    end

endmodule

// ===== rtl/prs_checker.sv =====
`timescale 1ns / 1ps

module prs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [prs_pkg::DATA_W-1:0] m_new_value,
    input logic signed [prs_pkg::DATA_W-1:0] m_residual,
    input logic                              m_sweep_done,
    input logic [prs_pkg::SUM_W-1:0]         m_sum_squares,
    input logic                              m_converged
);

    // no output word right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // sweep totals appear only on the last point
    a_totals_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sweep_done |-> (m_sum_squares == '0) && !m_converged)
        else $error("sweep totals on a non-final word");

    // the last point is a boundary point
    a_done_bnd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sweep_done |-> (m_residual == '0))
        else $error("final word has nonzero residual");

    // hold a stalled word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_value) && $stable(m_residual))
        else $error("stalled output word changed");

endmodule

bind poisson_relaxation_sweep prs_checker u_prs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_new_value   (m_new_value),
    .m_residual    (m_residual),
    .m_sweep_done  (m_sweep_done),
    .m_sum_squares (m_sum_squares),
    .m_converged   (m_converged)
);
